// File: sv/ldw_pkg.sv
// ----------------------------------------------------------------------------
// Lens distortion warp package
// Shared widths, register indexes, coefficient and result types, and the
// saturation helpers used across the warp pipeline.
// ----------------------------------------------------------------------------
package ldw_pkg;

  localparam int unsigned PIX_W      = 24;
  localparam int unsigned DELTA_W    = PIX_W + 1;
  localparam int unsigned COEF_W     = 32;
  localparam int unsigned Q_FRAC     = 28;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned SUM_W      = 38;

  localparam logic [PIX_W-1:0]  PIX_MAX    = {PIX_W{1'b1}};
  localparam logic [COEF_W-1:0] COSINE_RST = 32'h4000_0000;

  typedef logic [PIX_W-1:0]          pixel_t;
  typedef logic signed [DELTA_W-1:0] delta_t;
  typedef logic signed [COEF_W-1:0]  coef_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIAL_K1     = 3'd0,
    REG_RADIAL_K2     = 3'd1,
    REG_RADIAL_K3     = 3'd2,
    REG_TANGENTIAL_T1 = 3'd3,
    REG_TANGENTIAL_T2 = 3'd4,
    REG_ANGLE_SINE    = 3'd5,
    REG_ANGLE_COSINE  = 3'd6,
    REG_CENTER_UV     = 3'd7
  } cfg_reg_e;

  // Distortion coefficients as seen by the gain stages.
  typedef struct packed {
    coef_t k1;
    coef_t k2;
    coef_t k3;
    coef_t t1;
    coef_t t2;
  } coef_set_t;

  // One warped coordinate pair with its clip flag.
  typedef struct packed {
    logic   clipped;
    pixel_t warped_v;
    pixel_t warped_u;
  } result_t;

  // Clamp a signed sum to the signed 32 bit range.
  function automatic coef_t sat_s32(input logic signed [SUM_W-1:0] v);
    coef_t res;
    if ((&v[SUM_W-1:COEF_W-1]) || !(|v[SUM_W-1:COEF_W-1])) begin
      res = v[COEF_W-1:0];
    end else if (v[SUM_W-1]) begin
      res = {1'b1, {(COEF_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(COEF_W-1){1'b1}}};
    end
    return res;
  endfunction

  // Clamp an unsigned Q.28 product slice to 32 bits.
  function automatic logic [COEF_W-1:0] sat_u32(input logic [COEF_W+3:0] v);
    logic [COEF_W-1:0] res;
    if (|v[COEF_W+3:COEF_W]) begin
      res = {COEF_W{1'b1}};
    end else begin
      res = v[COEF_W-1:0];
    end
    return res;
  endfunction

endpackage

// File: sv/lens_distortion_warp_unit.sv
// ----------------------------------------------------------------------------
// Lens distortion warp unit
// Maps an undistorted pixel coordinate pair to its position under radial and
// tangential lens distortion, with saturation to the pixel range.
// ----------------------------------------------------------------------------
// Structure: an accepted request passes through 12 pipeline stages and then the
// output register before its result reaches the master side.
// Throughput: one request per cycle; a stalled output fills a one-entry skid
// stage and the slave side then stalls until it drains.
// Reset: asynchronous, active low; clears valid bits and sets the registers to
// their defaults (all zero, cosine 1.0).
module lens_distortion_warp_unit #(
  parameter int unsigned NORM_SHIFT      = 15,
  parameter int unsigned PIXEL_FRAC_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i,
  // Slave side.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [23:0] pixel_u, [47:24] pixel_v
  // Master side.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [23:0] warped_u, [47:24] warped_v
  output logic        m_axis_tuser    // [0] clipped
);
  import ldw_pkg::*;

  localparam int unsigned FRAC_BITS = NORM_SHIFT + PIXEL_FRAC_BITS;

  coef_set_t coef_q;
  coef_t     sine_q, cosine_q;
  logic [CFG_DATA_W-1:0] center_q;
  pixel_t    center_u, center_v;

  logic      pipe_en;
  logic      rad_valid, gain_valid, pipe_valid, push;
  logic [COEF_W-1:0] r2;
  delta_t    rad_dx, rad_dy, gain_dx, gain_dy;
  coef_t     gain, tang;
  result_t   pipe_result, out_q, skid_q;
  logic      out_valid_q, skid_valid_q;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q   <= '0;
      sine_q   <= '0;
      cosine_q <= COSINE_RST;
      center_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_RADIAL_K1:     coef_q.k1 <= cfg_data_i[COEF_W-1:0];
        REG_RADIAL_K2:     coef_q.k2 <= cfg_data_i[COEF_W-1:0];
        REG_RADIAL_K3:     coef_q.k3 <= cfg_data_i[COEF_W-1:0];
        REG_TANGENTIAL_T1: coef_q.t1 <= cfg_data_i[COEF_W-1:0];
        REG_TANGENTIAL_T2: coef_q.t2 <= cfg_data_i[COEF_W-1:0];
        REG_ANGLE_SINE:    sine_q    <= cfg_data_i[COEF_W-1:0];
        REG_ANGLE_COSINE:  cosine_q  <= cfg_data_i[COEF_W-1:0];
        REG_CENTER_UV:     center_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign center_u = center_q[2*PIX_W-1:PIX_W];
  assign center_v = center_q[PIX_W-1:0];

  // The whole pipeline advances unless the skid stage holds a result.
  assign pipe_en       = !skid_valid_q;
  assign s_axis_tready = pipe_en;

  ldw_radius #(
    .FRAC_BITS (FRAC_BITS)
  ) u_radius (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (pipe_en),
    .valid_i    (s_axis_tvalid),
    .pixel_u_i  (s_axis_tdata[PIX_W-1:0]),
    .pixel_v_i  (s_axis_tdata[2*PIX_W-1:PIX_W]),
    .center_u_i (center_u),
    .center_v_i (center_v),
    .valid_o    (rad_valid),
    .r2_o       (r2),
    .dx_o       (rad_dx),
    .dy_o       (rad_dy)
  );

  ldw_gain u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (rad_valid),
    .r2_i    (r2),
    .dx_i    (rad_dx),
    .dy_i    (rad_dy),
    .coef_i  (coef_q),
    .valid_o (gain_valid),
    .gain_o  (gain),
    .tang_o  (tang),
    .dx_o    (gain_dx),
    .dy_o    (gain_dy)
  );

  ldw_apply #(
    .FRAC_BITS (FRAC_BITS)
  ) u_apply (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (pipe_en),
    .valid_i    (gain_valid),
    .gain_i     (gain),
    .tang_i     (tang),
    .dx_i       (gain_dx),
    .dy_i       (gain_dy),
    .sine_i     (sine_q),
    .cosine_i   (cosine_q),
    .center_u_i (center_u),
    .center_v_i (center_v),
    .valid_o    (pipe_valid),
    .result_o   (pipe_result)
  );

  // A finished result leaves the pipeline whenever it advances.
  assign push = pipe_valid && pipe_en;

  // Output register with a one-entry skid stage behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push;
      end
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready) begin
      out_q <= skid_valid_q ? skid_q : pipe_result;
    end else if (push) begin
      skid_q <= pipe_result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.warped_v, out_q.warped_u};
  assign m_axis_tuser  = out_q.clipped;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds a result while the output register is empty");

  a_skid_catch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && out_valid_q && !m_axis_tready) |=> skid_valid_q)
    else $error("result arriving at a stalled output was not caught");

  a_skid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !m_axis_tready) |=> (skid_valid_q && $stable(skid_q)))
    else $error("skid stage lost its result while stalled");

endmodule

// File: sv/ldw_radius.sv
// ----------------------------------------------------------------------------
// Lens distortion warp: radius stages
// Three stages: offset from the optical center, squares, and the normalized
// squared radius r2 in unsigned Q4.28 with saturation.
// ----------------------------------------------------------------------------
module ldw_radius #(
  parameter int unsigned FRAC_BITS = 23
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  ldw_pkg::pixel_t pixel_u_i,
  input  ldw_pkg::pixel_t pixel_v_i,
  input  ldw_pkg::pixel_t center_u_i,
  input  ldw_pkg::pixel_t center_v_i,
  output logic            valid_o,
  output logic [31:0]     r2_o,
  output ldw_pkg::delta_t dx_o,
  output ldw_pkg::delta_t dy_o
);
  import ldw_pkg::*;

  localparam int SQ_SHIFT = 2 * int'(FRAC_BITS) - int'(Q_FRAC);
  localparam int SQ_SHR   = (SQ_SHIFT > 0) ? SQ_SHIFT : 0;
  localparam int SQ_SHL   = (SQ_SHIFT < 0) ? -SQ_SHIFT : 0;
  localparam int unsigned SQ_W = 2 * PIX_W;

  logic [2:0] valid_q;

  delta_t dx1_q, dy1_q, dx2_q, dy2_q, dx3_q, dy3_q;
  delta_t dx1_d, dy1_d;
  logic [SQ_W-1:0]   sqx_q, sqy_q;
  logic signed [2*DELTA_W-1:0] sqx_full, sqy_full;
  logic [SQ_W:0]     sq_sum;
  logic [63:0]       sq_wide, sq_norm;
  logic [COEF_W-1:0] r2_d, r2_q;

  // Offsets from the optical center.
  assign dx1_d = $signed({1'b0, pixel_u_i}) - $signed({1'b0, center_u_i});
  assign dy1_d = $signed({1'b0, pixel_v_i}) - $signed({1'b0, center_v_i});

  // Squares of the offsets; both are below 2^48.
  assign sqx_full = dx1_q * dx1_q;
  assign sqy_full = dy1_q * dy1_q;

  // Normalize the sum of squares to Q4.28 and saturate.
  assign sq_sum  = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign sq_wide = {{(64-SQ_W-1){1'b0}}, sq_sum};
  assign sq_norm = (sq_wide >> SQ_SHR) << SQ_SHL;
  assign r2_d    = (|sq_norm[63:COEF_W]) ? {COEF_W{1'b1}} : sq_norm[COEF_W-1:0];

  // Valid bits move with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  // Stage data registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx1_q <= dx1_d;
      dy1_q <= dy1_d;
      sqx_q <= sqx_full[SQ_W-1:0];
      sqy_q <= sqy_full[SQ_W-1:0];
      dx2_q <= dx1_q;
      dy2_q <= dy1_q;
      r2_q  <= r2_d;
      dx3_q <= dx2_q;
      dy3_q <= dy2_q;
    end
  end

  assign valid_o = valid_q[2];
  assign r2_o    = r2_q;
  assign dx_o    = dx3_q;
  assign dy_o    = dy3_q;

endmodule

// File: sv/ldw_gain.sv
// ----------------------------------------------------------------------------
// Lens distortion warp: gain stages
// Six stages that form r4 and r6 and accumulate the radial gain
// 1 + k1*r2 + k2*r4 + k3*r6 and the tangential term t1*r2 + t2*r4.
// ----------------------------------------------------------------------------
module ldw_gain (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [31:0]        r2_i,
  input  ldw_pkg::delta_t    dx_i,
  input  ldw_pkg::delta_t    dy_i,
  input  ldw_pkg::coef_set_t coef_i,
  output logic               valid_o,
  output ldw_pkg::coef_t     gain_o,
  output ldw_pkg::coef_t     tang_o,
  output ldw_pkg::delta_t    dx_o,
  output ldw_pkg::delta_t    dy_o
);
  import ldw_pkg::*;

  localparam int unsigned STAGES = 6;
  localparam int unsigned TERM_W = 64 - Q_FRAC;
  localparam logic signed [SUM_W-1:0] ONE_Q28 = SUM_W'(1) <<< Q_FRAC;

  logic [STAGES-1:0] valid_q;
  delta_t dx_dly_q [STAGES];
  delta_t dy_dly_q [STAGES];

  // Stage 1 products.
  logic [63:0]        p22_q;
  logic signed [63:0] pk1_q, pt1_q;
  logic [COEF_W-1:0]  r2a_q;
  // Stage 2 partial sums.
  logic [COEF_W-1:0]       r4_q, r2b_q;
  logic signed [SUM_W-1:0] sa_q, st_q;
  // Stage 3 products.
  logic [63:0]             p24_q;
  logic signed [63:0]      pk2_q, pt2_q;
  logic signed [SUM_W-1:0] sab_q, stb_q;
  // Stage 4 sums.
  logic [COEF_W-1:0]       r6_q;
  logic signed [SUM_W-1:0] sac_q;
  coef_t                   tang4_q;
  // Stage 5 product.
  logic signed [63:0]      pk3_q;
  logic signed [SUM_W-1:0] sad_q;
  coef_t                   tang5_q;
  // Stage 6 result.
  coef_t gain_q, tang6_q;

  logic [63:0]        p22_d, p24_d;
  logic signed [63:0] pk1_d, pt1_d, pk2_d, pt2_d, pk3_d;
  logic signed [TERM_W-1:0] k1_term, t1_term, k2_term, t2_term, k3_term;

  // Multiplier inputs: unsigned radius powers against each other or against signed coefficients.
  assign p22_d = r2_i * r2_i;
  assign pk1_d = coef_i.k1 * $signed({1'b0, r2_i});
  assign pt1_d = coef_i.t1 * $signed({1'b0, r2_i});
  assign p24_d = r2b_q * r4_q;
  assign pk2_d = coef_i.k2 * $signed({1'b0, r4_q});
  assign pt2_d = coef_i.t2 * $signed({1'b0, r4_q});
  assign pk3_d = coef_i.k3 * $signed({1'b0, r6_q});

  // Taking the upper bits is a floor shift by the Q4.28 fraction.
  assign k1_term = pk1_q[63:Q_FRAC];
  assign t1_term = pt1_q[63:Q_FRAC];
  assign k2_term = pk2_q[63:Q_FRAC];
  assign t2_term = pt2_q[63:Q_FRAC];
  assign k3_term = pk3_q[63:Q_FRAC];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[STAGES-2:0], valid_i};
    end
  end

  // Offsets ride alongside the gain computation.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_dly_q[0] <= dx_i;
      dy_dly_q[0] <= dy_i;
      for (int i = 1; i < STAGES; i++) begin
        dx_dly_q[i] <= dx_dly_q[i-1];
        dy_dly_q[i] <= dy_dly_q[i-1];
      end
    end
  end

  // Gain pipeline data registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p22_q   <= p22_d;
      pk1_q   <= pk1_d;
      pt1_q   <= pt1_d;
      r2a_q   <= r2_i;

      r4_q    <= sat_u32(p22_q[63:Q_FRAC]);
      r2b_q   <= r2a_q;
      sa_q    <= ONE_Q28 + SUM_W'(k1_term);
      st_q    <= SUM_W'(t1_term);

      p24_q   <= p24_d;
      pk2_q   <= pk2_d;
      pt2_q   <= pt2_d;
      sab_q   <= sa_q;
      stb_q   <= st_q;

      r6_q    <= sat_u32(p24_q[63:Q_FRAC]);
      sac_q   <= sab_q + SUM_W'(k2_term);
      tang4_q <= sat_s32(stb_q + SUM_W'(t2_term));

      pk3_q   <= pk3_d;
      sad_q   <= sac_q;
      tang5_q <= tang4_q;

      gain_q  <= sat_s32(sad_q + SUM_W'(k3_term));
      tang6_q <= tang5_q;
    end
  end

  assign valid_o = valid_q[STAGES-1];
  assign gain_o  = gain_q;
  assign tang_o  = tang6_q;
  assign dx_o    = dx_dly_q[STAGES-1];
  assign dy_o    = dy_dly_q[STAGES-1];

endmodule

// File: sv/ldw_apply.sv
// ----------------------------------------------------------------------------
// Lens distortion warp: apply stages
// Three stages: gain and tangential products, rounding back to pixel units,
// and adding the center with saturation to the pixel range.
// ----------------------------------------------------------------------------
module ldw_apply #(
  parameter int unsigned FRAC_BITS = 23
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  ldw_pkg::coef_t   gain_i,
  input  ldw_pkg::coef_t   tang_i,
  input  ldw_pkg::delta_t  dx_i,
  input  ldw_pkg::delta_t  dy_i,
  input  ldw_pkg::coef_t   sine_i,
  input  ldw_pkg::coef_t   cosine_i,
  input  ldw_pkg::pixel_t  center_u_i,
  input  ldw_pkg::pixel_t  center_v_i,
  output logic             valid_o,
  output ldw_pkg::result_t result_o
);
  import ldw_pkg::*;

  localparam int unsigned TRIG_SHIFT = (FRAC_BITS >= 32) ? 0 : 32 - FRAC_BITS;
  localparam int unsigned PA_W  = COEF_W + DELTA_W;
  localparam int unsigned ACC_W = 65;
  localparam int unsigned ACC_FRAC = 26;
  localparam int unsigned POS_W = ACC_W - ACC_FRAC;
  localparam int unsigned PLC_W = POS_W + 1;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (ACC_FRAC - 1);

  logic [2:0] valid_q;

  logic signed [PA_W-1:0]  pax_q, pay_q;
  logic signed [63:0]      pts_q, ptc_q;
  logic signed [ACC_W-1:0] accx, accy;
  logic signed [POS_W-1:0] rx_q, ry_q;
  logic signed [PLC_W-1:0] placex, placey;
  pixel_t                  u_d, v_d;
  logic                    clip_u, clip_v;
  result_t                 result_q;

  // Stage 1: gain times offset, tangential term along the configured angle.
  logic signed [PA_W-1:0] pax_d, pay_d;
  logic signed [63:0]     pts_d, ptc_d;
  assign pax_d = gain_i * dx_i;
  assign pay_d = gain_i * dy_i;
  assign pts_d = tang_i * sine_i;
  assign ptc_d = tang_i * cosine_i;

  // Stage 2: combine with 26 fraction bits and round half up.
  assign accx = (ACC_W'(pax_q) >>> 2) - (ACC_W'(pts_q) >>> TRIG_SHIFT) + ROUND_HALF;
  assign accy = (ACC_W'(pay_q) >>> 2) + (ACC_W'(ptc_q) >>> TRIG_SHIFT) + ROUND_HALF;

  // Stage 3: add the center back and clamp to the pixel range.
  assign placex = PLC_W'($signed({1'b0, center_u_i})) + PLC_W'(rx_q);
  assign placey = PLC_W'($signed({1'b0, center_v_i})) + PLC_W'(ry_q);

  always_comb begin
    clip_u = 1'b0;
    clip_v = 1'b0;
    u_d    = placex[PIX_W-1:0];
    v_d    = placey[PIX_W-1:0];
    if (placex[PLC_W-1]) begin
      clip_u = 1'b1;
      u_d    = '0;
    end else if (|placex[PLC_W-2:PIX_W]) begin
      clip_u = 1'b1;
      u_d    = PIX_MAX;
    end
    if (placey[PLC_W-1]) begin
      clip_v = 1'b1;
      v_d    = '0;
    end else if (|placey[PLC_W-2:PIX_W]) begin
      clip_v = 1'b1;
      v_d    = PIX_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  // Stage data registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pax_q             <= pax_d;
      pay_q             <= pay_d;
      pts_q             <= pts_d;
      ptc_q             <= ptc_d;
      rx_q              <= accx[ACC_W-1:ACC_FRAC];
      ry_q              <= accy[ACC_W-1:ACC_FRAC];
      result_q.warped_u <= u_d;
      result_q.warped_v <= v_d;
      result_q.clipped  <= clip_u | clip_v;
    end
  end

  assign valid_o  = valid_q[2];
  assign result_o = result_q;

  // A clamped coordinate always sits at one end of the range.
  a_clip_u_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && valid_q[1] && clip_u) |-> (u_d == '0 || u_d == PIX_MAX))
    else $error("clamped column is not at a range end");

  a_clip_v_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && valid_q[1] && clip_v) |-> (v_d == '0 || v_d == PIX_MAX))
    else $error("clamped row is not at a range end");

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!en_i && valid_q[2]) |=> (valid_q[2] && $stable(result_q)))
    else $error("result changed while the pipeline was stalled");

endmodule
